>>> sv/ppse_pkg.sv
// ppse_pkg: shared types and constants of the postfix/prefix stack evaluator.
// Holds character codes, status codes and the arithmetic unit command/response.
// No dependencies.
package ppse_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;
  localparam int DATA_W = 32;

  // Expression characters
  localparam logic [7:0] CH_ZERO   = 8'h30; // '0'
  localparam logic [7:0] CH_POW    = 8'h5E; // '^'
  localparam logic [7:0] CH_DOLLAR = 8'h24; // '$'
  localparam logic [7:0] CH_MUL    = 8'h2A; // '*'
  localparam logic [7:0] CH_DIV    = 8'h2F; // '/'
  localparam logic [7:0] CH_ADD    = 8'h2B; // '+'
  localparam logic [7:0] CH_SUB    = 8'h2D; // '-'

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_DIV = 2'd1,
    ALU_POW = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

>>> sv/ppse_if.sv
// ppse_if: valid/ready channel interfaces of the stack evaluator.
// Expression characters in, results out, and the mode register write channel.
// Depends on nothing.
interface ppse_expr_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink (input valid, input symbol, input end_of_expr, output ready);
endinterface

interface ppse_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

interface ppse_cfg_if;
  logic valid;
  logic ready;
  logic prefix_mode;

  modport source (output valid, output prefix_mode, input ready);
  modport sink (input valid, input prefix_mode, output ready);
endinterface

>>> sv/ppse_stack_mem.sv
// ppse_stack_mem: operand stack storage, one write port and one read port.
// Read data is registered. Depends on nothing.
module ppse_stack_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/ppse_alu.sv
// ppse_alu: arithmetic unit for multiply, divide and power; divide and power iterate.
// Divide is restoring, one quotient bit a cycle; power is square-and-multiply.
// Depends on ppse_pkg.
module ppse_alu (
  input  logic               clk,
  input  logic               rst,
  input  ppse_pkg::alu_cmd_t cmd,
  output ppse_pkg::alu_rsp_t rsp
);

  logic              busy;
  logic              done;
  ppse_pkg::alu_op_t op;
  logic [31:0]       acc;   // product, quotient or power result
  logic [31:0]       base;
  logic [31:0]       expo;
  logic [31:0]       rem;
  logic [31:0]       dvs;
  logic              neg;
  logic [4:0]        cnt;

  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] rem_new;
  logic [31:0] q_new;
  logic [31:0] pow_special;

  always_comb begin
    mag_a   = cmd.a[31] ? (32'd0 - cmd.a) : cmd.a;
    mag_b   = cmd.b[31] ? (32'd0 - cmd.b) : cmd.b;
    rem_sh  = {rem, acc[31]};
    diff    = rem_sh - {1'b0, dvs};
    ge      = !diff[32];
    rem_new = ge ? diff[31:0] : rem_sh[31:0];
    q_new   = {acc[30:0], ge};
    // negative exponent: only unit-magnitude bases survive
    if (cmd.a == 32'd1) begin
      pow_special = 32'd1;
    end else if (cmd.a == 32'hFFFF_FFFF) begin
      pow_special = cmd.b[0] ? 32'hFFFF_FFFF : 32'd1;
    end else begin
      pow_special = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        op <= cmd.op;
        unique case (cmd.op)
          ppse_pkg::ALU_MUL: begin
            acc  <= cmd.a * cmd.b;
            done <= 1'b1;
          end
          ppse_pkg::ALU_DIV: begin
            acc  <= mag_a;
            rem  <= 32'd0;
            dvs  <= mag_b;
            neg  <= cmd.a[31] ^ cmd.b[31];
            cnt  <= 5'd0;
            busy <= 1'b1;
          end
          ppse_pkg::ALU_POW: begin
            if (cmd.b[31]) begin
              acc  <= pow_special;
              done <= 1'b1;
            end else begin
              acc  <= 32'd1;
              base <= cmd.a;
              expo <= cmd.b;
              busy <= 1'b1;
            end
          end
          default: begin
            done <= 1'b1;
          end
        endcase
      end else if (busy) begin
        unique case (op)
          ppse_pkg::ALU_DIV: begin
            rem <= rem_new;
            cnt <= cnt + 5'd1;
            if (cnt == 5'd31) begin
              acc  <= neg ? (32'd0 - q_new) : q_new;
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              acc <= q_new;
            end
          end
          ppse_pkg::ALU_POW: begin
            if (expo == 32'd0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end else begin
              if (expo[0]) begin
                acc <= acc * base;
              end
              base <= base * base;
              expo <= expo >> 1;
            end
          end
          default: begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = acc;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !busy)
    else $error("arithmetic unit started while busy");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("arithmetic unit done while still busy");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cmd.start))
    else $error("arithmetic unit went busy without a start");

endmodule

>>> sv/postfix_prefix_stack_evaluator.sv
// postfix_prefix_stack_evaluator: top level of the stack expression evaluator.
// Depends on ppse_pkg, ppse_if (channel interfaces), ppse_stack_mem, ppse_alu.
//
// Usage:
//   expr   - one ASCII character per transaction, end_of_expr on the last one.
//            Characters + - * / ^ $ are operators; anything else pushes
//            (symbol - 48). In prefix mode feed the expression last to first.
//   result - one transaction per expression: the top of the stack (0 when
//            empty) and a status (first error, else empty, else ok).
//   cfg    - writes prefix_mode; always ready. Write it only between items.
// Path per character, accept to next accept: a push goes straight back to
//   idle; + and - finish in the load state; * / ^ $ wait in the execute
//   state for the arithmetic unit, but / with a zero divisor finishes in
//   the load state; ^ and $ take one step per exponent bit. The final
//   character passes through the finish state to load the output register.
//   Throughput is set by the shared arithmetic unit, which iterates one
//   quotient bit or one exponent bit a cycle; every operator with two
//   operands waits in the load state for the registered second-operand read.
// The top of stack lives in a register; the memory holds the entries below.
// Reset empties the stack, clears the error and selects postfix mode; no
// clearing pass is needed since only written entries are read.
// A stalled result register holds its transaction; the block keeps accepting
// characters of the next expression until that one's result needs the register.
module postfix_prefix_stack_evaluator #(
  parameter int STACK_DEPTH = ppse_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  ppse_expr_if.sink     expr,
  ppse_result_if.source result,
  ppse_cfg_if.sink      cfg
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_POW
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_EXEC,
    S_FINISH
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  ppse_pkg::status_t err;
  logic [31:0]       tos;
  op_t               op;
  logic              last;
  logic              mode;
  logic              out_valid;
  logic [31:0]       out_value;
  logic [2:0]        out_status;

  logic              accept;
  op_t               sym_op;
  logic [31:0]       push_val;
  logic [CW-1:0]     count_m1;
  logic [CW-1:0]     count_m2;
  logic              full;
  logic              mem_we;
  logic              mem_re;
  logic [31:0]       mem_rdata;
  logic [31:0]       opa;
  logic [31:0]       opb;
  ppse_pkg::alu_cmd_t alu_cmd;
  ppse_pkg::alu_rsp_t alu_rsp;
  logic              out_free;
  logic              out_load;

  // Decode the incoming character.
  always_comb begin
    unique case (expr.symbol)
      ppse_pkg::CH_ADD:    sym_op = OP_ADD;
      ppse_pkg::CH_SUB:    sym_op = OP_SUB;
      ppse_pkg::CH_MUL:    sym_op = OP_MUL;
      ppse_pkg::CH_DIV:    sym_op = OP_DIV;
      ppse_pkg::CH_POW:    sym_op = OP_POW;
      ppse_pkg::CH_DOLLAR: sym_op = OP_POW;
      default:             sym_op = OP_NONE;
    endcase
  end

  assign expr.ready = (state == S_IDLE);
  assign accept     = expr.valid && expr.ready;
  assign cfg.ready  = 1'b1;
  assign push_val   = 32'(expr.symbol) - 32'(ppse_pkg::CH_ZERO);
  assign count_m1   = count - CW'(1);
  assign count_m2   = count - CW'(2);
  assign full       = (count == CW'(STACK_DEPTH));

  // Push spills the old top into memory; an operator fetches the entry below.
  assign mem_we = accept && (sym_op == OP_NONE) && (count != '0) && !full;
  assign mem_re = accept && (sym_op != OP_NONE) && (count >= CW'(2));

  ppse_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (AW),
    .DATA_W (ppse_pkg::DATA_W)
  ) u_stack_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_m1[AW-1:0]),
    .wdata (tos),
    .re    (mem_re),
    .raddr (count_m2[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Postfix: second-popped op first-popped; prefix swaps them.
  assign opa = mode ? tos : mem_rdata;
  assign opb = mode ? mem_rdata : tos;

  always_comb begin
    alu_cmd.a     = opa;
    alu_cmd.b     = opb;
    alu_cmd.start = 1'b0;
    alu_cmd.op    = ppse_pkg::ALU_MUL;
    if (state == S_LOAD) begin
      unique case (op)
        OP_MUL: alu_cmd.start = 1'b1;
        OP_DIV: begin
          alu_cmd.start = (opb != 32'd0);
          alu_cmd.op    = ppse_pkg::ALU_DIV;
        end
        OP_POW: begin
          alu_cmd.start = 1'b1;
          alu_cmd.op    = ppse_pkg::ALU_POW;
        end
        default: alu_cmd.start = 1'b0;
      endcase
    end
  end

  ppse_alu u_alu (
    .clk (clk),
    .rst (rst),
    .cmd (alu_cmd),
    .rsp (alu_rsp)
  );

  assign out_free = !out_valid || result.ready;
  assign out_load = (state == S_FINISH) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      err       <= ppse_pkg::ST_OK;
      mode      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        mode <= cfg.prefix_mode;
      end
      // load a new result, or drop the one the receiver took
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op   <= sym_op;
            last <= expr.end_of_expr;
            if (sym_op == OP_NONE) begin
              if (full) begin
                if (err == ppse_pkg::ST_OK) begin
                  err <= ppse_pkg::ST_OVERFLOW;
                end
              end else begin
                tos   <= push_val;
                count <= count + CW'(1);
              end
              state <= expr.end_of_expr ? S_FINISH : S_IDLE;
            end else if (count < CW'(2)) begin
              if (err == ppse_pkg::ST_OK) begin
                err <= ppse_pkg::ST_UNDERFLOW;
              end
              state <= expr.end_of_expr ? S_FINISH : S_IDLE;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          priority if (op == OP_ADD) begin
            tos   <= opa + opb;
            count <= count_m1;
            state <= last ? S_FINISH : S_IDLE;
          end else if (op == OP_SUB) begin
            tos   <= opa - opb;
            count <= count_m1;
            state <= last ? S_FINISH : S_IDLE;
          end else if (op == OP_DIV && opb == 32'd0) begin
            // divide by zero pushes 0
            tos   <= 32'd0;
            count <= count_m1;
            if (err == ppse_pkg::ST_OK) begin
              err <= ppse_pkg::ST_DIVZERO;
            end
            state <= last ? S_FINISH : S_IDLE;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (alu_rsp.done) begin
            tos   <= alu_rsp.result;
            count <= count_m1;
            state <= last ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          // hold until the result register is free, then drop the stack
          if (out_free) begin
            out_value <= (count != '0) ? tos : 32'd0;
            if (err != ppse_pkg::ST_OK) begin
              out_status <= err;
            end else if (count == '0) begin
              out_status <= ppse_pkg::ST_EMPTY;
            end else begin
              out_status <= ppse_pkg::ST_OK;
            end
            count <= '0;
            err   <= ppse_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid  = out_valid;
  assign result.value  = out_value;
  assign result.status = out_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_read_has_operands: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> (state == S_LOAD) && (count >= CW'(2)))
    else $error("operand fetch without two stack entries");

  a_alu_done_in_exec: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == S_EXEC))
    else $error("arithmetic result arrived outside execute");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (count == '0) && out_valid &&
      (err == ppse_pkg::ST_OK))
    else $error("expression end did not clear the stack");

endmodule
